// ===== hdl/operator_token_classifier_defines.svh =====
// Assertion macros for the operator token classifier checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef OPERATOR_TOKEN_CLASSIFIER_DEFINES_SVH
`define OPERATOR_TOKEN_CLASSIFIER_DEFINES_SVH

// Clocked assertion, disabled while reset is asserted (active low).
`define OTC_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("otc assertion failed");

// Same, with a caller supplied message string.
`define OTC_ASSERT_MSG(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

`endif

// ===== hdl/otc_pkg.sv =====
// Shared types and constants for the operator token classifier.
// No dependencies; used by the interfaces and every module of the block.
package otc_pkg;

  localparam int unsigned CP_W   = 21;
  localparam int unsigned CLS_W  = 4;
  localparam int unsigned LEN_W  = 8;
  localparam int unsigned MASK_W = 12;
  localparam int unsigned ST_W   = 4;
  localparam int unsigned KIND_W = 2;

  localparam logic [LEN_W-1:0] LEN_MAX = 8'hFF;

  // scan state codes
  localparam logic [ST_W-1:0] ST_ARROW      = 4'd0;
  localparam logic [ST_W-1:0] ST_ASSIGN     = 4'd1;
  localparam logic [ST_W-1:0] ST_COLON      = 4'd2;
  localparam logic [ST_W-1:0] ST_COLONCOLON = 4'd3;
  localparam logic [ST_W-1:0] ST_DOT        = 4'd4;
  localparam logic [ST_W-1:0] ST_EQUAL      = 4'd5;
  localparam logic [ST_W-1:0] ST_MAYBEARROW = 4'd6;
  localparam logic [ST_W-1:0] ST_MINUS      = 4'd7;
  localparam logic [ST_W-1:0] ST_REGULAR    = 4'd8;

  // token classes
  localparam logic [CLS_W-1:0] CLS_OP10L    = 4'd0;
  localparam logic [CLS_W-1:0] CLS_OP10R    = 4'd1;
  localparam logic [CLS_W-1:0] CLS_OP9      = 4'd2;
  localparam logic [CLS_W-1:0] CLS_OP8      = 4'd3;
  localparam logic [CLS_W-1:0] CLS_OP7      = 4'd4;
  localparam logic [CLS_W-1:0] CLS_OP6      = 4'd5;
  localparam logic [CLS_W-1:0] CLS_OP5      = 4'd6;
  localparam logic [CLS_W-1:0] CLS_OP2      = 4'd7;
  localparam logic [CLS_W-1:0] CLS_SIGIL    = 4'd8;
  localparam logic [CLS_W-1:0] CLS_OP1      = 4'd9;
  localparam logic [CLS_W-1:0] CLS_OP0      = 4'd10;
  localparam logic [CLS_W-1:0] CLS_UNARY    = 4'd11;
  localparam logic [CLS_W-1:0] CLS_NONE     = 4'd15;

  // first character kinds
  localparam logic [KIND_W-1:0] KIND_PLAIN = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SIGIL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REL   = 2'd2;

  // ASCII characters of interest
  localparam logic [CP_W-1:0] CH_LF      = 21'h0A;
  localparam logic [CP_W-1:0] CH_CR      = 21'h0D;
  localparam logic [CP_W-1:0] CH_SPACE   = 21'h20;
  localparam logic [CP_W-1:0] CH_BANG    = 21'h21;
  localparam logic [CP_W-1:0] CH_DOLLAR  = 21'h24;
  localparam logic [CP_W-1:0] CH_PERCENT = 21'h25;
  localparam logic [CP_W-1:0] CH_AMP     = 21'h26;
  localparam logic [CP_W-1:0] CH_STAR    = 21'h2A;
  localparam logic [CP_W-1:0] CH_PLUS    = 21'h2B;
  localparam logic [CP_W-1:0] CH_MINUS   = 21'h2D;
  localparam logic [CP_W-1:0] CH_DOT     = 21'h2E;
  localparam logic [CP_W-1:0] CH_SLASH   = 21'h2F;
  localparam logic [CP_W-1:0] CH_ZERO    = 21'h30;
  localparam logic [CP_W-1:0] CH_NINE    = 21'h39;
  localparam logic [CP_W-1:0] CH_COLON   = 21'h3A;
  localparam logic [CP_W-1:0] CH_LT      = 21'h3C;
  localparam logic [CP_W-1:0] CH_EQ      = 21'h3D;
  localparam logic [CP_W-1:0] CH_GT      = 21'h3E;
  localparam logic [CP_W-1:0] CH_QUEST   = 21'h3F;
  localparam logic [CP_W-1:0] CH_AT      = 21'h40;
  localparam logic [CP_W-1:0] CH_BSLASH  = 21'h5C;
  localparam logic [CP_W-1:0] CH_CARET   = 21'h5E;
  localparam logic [CP_W-1:0] CH_PIPE    = 21'h7C;
  localparam logic [CP_W-1:0] CH_TILDE   = 21'h7E;

  // decoded view of one character
  typedef struct packed {
    logic [CLS_W-1:0] cls;
    logic             is_op;
    logic             is_tilde;
    logic             is_minus;
    logic             is_eq;
    logic             is_colon;
    logic             is_gt;
    logic             is_dot;
    logic             is_at;
    logic             is_rel;    // < > ! = ~ ?
    logic             is_numeral;
    logic             is_blank;  // space, LF, CR
  } char_info_t;

  // one step's outcome from the scanner
  typedef struct packed {
    logic             valid;
    logic             accepted;
    logic [CLS_W-1:0] token_class;
    logic [LEN_W-1:0] op_length;
  } scan_res_t;

endpackage

// ===== hdl/otc_if.sv =====
// Valid/ready channel interfaces for the operator token classifier.
// Depends on otc_pkg for field widths.
interface otc_in_if;
  logic                          valid;
  logic                          ready;
  logic [otc_pkg::CP_W-1:0]      code_point;
  logic                          start_req;
  logic                          immediate;
  logic                          binary_all_valid;
  logic                          unary_any_valid;
  logic [otc_pkg::MASK_W-1:0]    allowed_mask;

  modport source (output valid, code_point, start_req, immediate, binary_all_valid,
                  unary_any_valid, allowed_mask, input ready);
  modport sink   (input valid, code_point, start_req, immediate, binary_all_valid,
                  unary_any_valid, allowed_mask, output ready);
endinterface

interface otc_out_if;
  logic                          valid;
  logic                          ready;
  logic                          accepted;
  logic [otc_pkg::CLS_W-1:0]     token_class;
  logic [otc_pkg::LEN_W-1:0]     op_length;

  modport source (output valid, accepted, token_class, op_length, input ready);
  modport sink   (input valid, accepted, token_class, op_length, output ready);
endinterface

// ===== hdl/otc_char_class.sv =====
// Character decoder: precedence class and special-character flags.
// Depends on otc_pkg.
module otc_char_class (
  input  logic [otc_pkg::CP_W-1:0] code_point_i,
  output otc_pkg::char_info_t      info_o
);

  logic [otc_pkg::CLS_W-1:0] cls;

  always_comb begin
    case (code_point_i)
      otc_pkg::CH_DOLLAR:  cls = otc_pkg::CLS_OP10L;
      otc_pkg::CH_CARET:   cls = otc_pkg::CLS_OP10R;
      otc_pkg::CH_STAR, otc_pkg::CH_PERCENT, otc_pkg::CH_BSLASH, otc_pkg::CH_SLASH,
      21'h2219, 21'h2218, 21'h00D7, 21'h2605, 21'h2297, 21'h2298, 21'h2299,
      21'h229B, 21'h22A0, 21'h22A1, 21'h2229, 21'h2227, 21'h2293:
        cls = otc_pkg::CLS_OP9;
      otc_pkg::CH_PLUS, otc_pkg::CH_MINUS, otc_pkg::CH_TILDE, otc_pkg::CH_PIPE,
      21'h00B1, 21'h2295, 21'h2296, 21'h229E, 21'h229F, 21'h222A, 21'h2228,
      21'h2294:
        cls = otc_pkg::CLS_OP8;
      otc_pkg::CH_AMP:     cls = otc_pkg::CLS_OP7;
      otc_pkg::CH_DOT:     cls = otc_pkg::CLS_OP6;
      otc_pkg::CH_EQ, otc_pkg::CH_LT, otc_pkg::CH_GT, otc_pkg::CH_BANG:
        cls = otc_pkg::CLS_OP5;
      otc_pkg::CH_COLON, otc_pkg::CH_QUEST, otc_pkg::CH_AT:
        cls = otc_pkg::CLS_OP2;
      default:             cls = otc_pkg::CLS_NONE;
    endcase
  end

  always_comb begin
    info_o          = '0;
    info_o.cls      = cls;
    info_o.is_op    = (cls != otc_pkg::CLS_NONE);
    info_o.is_tilde = (code_point_i == otc_pkg::CH_TILDE);
    info_o.is_minus = (code_point_i == otc_pkg::CH_MINUS);
    info_o.is_eq    = (code_point_i == otc_pkg::CH_EQ);
    info_o.is_colon = (code_point_i == otc_pkg::CH_COLON);
    info_o.is_gt    = (code_point_i == otc_pkg::CH_GT);
    info_o.is_dot   = (code_point_i == otc_pkg::CH_DOT);
    info_o.is_at    = (code_point_i == otc_pkg::CH_AT);
    info_o.is_rel   = code_point_i inside {otc_pkg::CH_LT, otc_pkg::CH_GT,
                                           otc_pkg::CH_BANG, otc_pkg::CH_EQ,
                                           otc_pkg::CH_TILDE, otc_pkg::CH_QUEST};
    info_o.is_numeral = code_point_i inside {[otc_pkg::CH_ZERO:otc_pkg::CH_NINE]};
    info_o.is_blank = code_point_i inside {otc_pkg::CH_SPACE, otc_pkg::CH_LF,
                                           otc_pkg::CH_CR};
  end

endmodule

// ===== hdl/otc_scan.sv =====
// Operator scan state machine: start, arrow/assign/colon/dot tracking and
// end-of-token classification. Depends on otc_pkg.
module otc_scan (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic                       start_i,
  input  logic                       immediate_i,
  input  logic                       binary_all_valid_i,
  input  logic                       unary_any_valid_i,
  input  logic [otc_pkg::MASK_W-1:0] allowed_mask_i,
  input  otc_pkg::char_info_t        info_i,
  output otc_pkg::scan_res_t         res_o
);

  logic                        scanning_q, scanning_d;
  logic [otc_pkg::ST_W-1:0]    state_q, state_d;
  logic [otc_pkg::CLS_W-1:0]   first_cls_q, first_cls_d;
  logic [otc_pkg::KIND_W-1:0]  kind_q, kind_d;
  logic                        imm_q, imm_d;
  logic                        bin_q, bin_d;
  logic [otc_pkg::MASK_W-1:0]  mask_q, mask_d;
  logic [otc_pkg::LEN_W-1:0]   len_q, len_d;

  logic                        arrowable;
  logic [otc_pkg::ST_W-1:0]    st_base;
  logic [otc_pkg::ST_W-1:0]    adv_state;
  logic [otc_pkg::ST_W-1:0]    start_state;
  logic                        end_bad;
  logic [otc_pkg::CLS_W-1:0]   cls_a, cls_b, cls_c;
  logic                        fin_ok;

  // next state for one more operator character
  always_comb begin
    arrowable = state_q inside {otc_pkg::ST_ASSIGN, otc_pkg::ST_EQUAL,
                                otc_pkg::ST_MAYBEARROW, otc_pkg::ST_MINUS};
    st_base   = arrowable ? otc_pkg::ST_REGULAR : state_q;
    if (arrowable && info_i.is_gt) begin
      adv_state = otc_pkg::ST_ARROW;
    end else if (info_i.is_tilde || info_i.is_minus) begin
      adv_state = otc_pkg::ST_MAYBEARROW;
    end else if (info_i.is_eq) begin
      adv_state = otc_pkg::ST_ASSIGN;
    end else if (info_i.is_colon && st_base == otc_pkg::ST_COLON) begin
      adv_state = otc_pkg::ST_COLONCOLON;
    end else begin
      adv_state = otc_pkg::ST_REGULAR;
    end
  end

  // state entered on the first character
  always_comb begin
    if (info_i.is_dot) begin
      start_state = otc_pkg::ST_DOT;
    end else if (info_i.is_eq) begin
      start_state = otc_pkg::ST_EQUAL;
    end else if (info_i.is_colon) begin
      start_state = otc_pkg::ST_COLON;
    end else if (info_i.is_minus) begin
      start_state = otc_pkg::ST_MINUS;
    end else if (info_i.is_tilde) begin
      start_state = otc_pkg::ST_MAYBEARROW;
    end else begin
      start_state = otc_pkg::ST_REGULAR;
    end
  end

  // end-of-token classification
  always_comb begin
    end_bad = (state_q inside {otc_pkg::ST_EQUAL, otc_pkg::ST_COLON,
                               otc_pkg::ST_COLONCOLON, otc_pkg::ST_DOT})
              || (state_q == otc_pkg::ST_MINUS && info_i.is_numeral);
    if (state_q == otc_pkg::ST_ARROW) begin
      cls_a = otc_pkg::CLS_OP0;
    end else if (state_q == otc_pkg::ST_ASSIGN && kind_q != otc_pkg::KIND_REL) begin
      cls_a = otc_pkg::CLS_OP1;
    end else begin
      cls_a = first_cls_q;
    end
    // spaced on the left but not on the right reads as unary
    cls_b = (!imm_q && !info_i.is_blank) ? otc_pkg::CLS_UNARY : cls_a;
    if (!bin_q || cls_b == otc_pkg::CLS_UNARY) begin
      cls_c = (kind_q == otc_pkg::KIND_SIGIL) ? otc_pkg::CLS_SIGIL : otc_pkg::CLS_UNARY;
    end else begin
      cls_c = cls_b;
    end
    fin_ok = !end_bad && mask_q[cls_c];
  end

  always_comb begin
    scanning_d  = scanning_q;
    state_d     = state_q;
    first_cls_d = first_cls_q;
    kind_d      = kind_q;
    imm_d       = imm_q;
    bin_d       = bin_q;
    mask_d      = mask_q;
    len_d       = len_q;
    res_o       = '0;
    if (step_i) begin
      if (start_i) begin
        scanning_d = 1'b0;
        if ((!binary_all_valid_i && !unary_any_valid_i) || !info_i.is_op) begin
          res_o.valid = 1'b1;
        end else begin
          scanning_d  = 1'b1;
          state_d     = start_state;
          first_cls_d = info_i.cls;
          if (info_i.is_at) begin
            kind_d = otc_pkg::KIND_SIGIL;
          end else if (info_i.is_rel) begin
            kind_d = otc_pkg::KIND_REL;
          end else begin
            kind_d = otc_pkg::KIND_PLAIN;
          end
          imm_d  = immediate_i;
          bin_d  = binary_all_valid_i;
          mask_d = allowed_mask_i;
          len_d  = {{(otc_pkg::LEN_W-1){1'b0}}, 1'b1};
        end
      end else if (scanning_q) begin
        if (info_i.is_op) begin
          state_d = adv_state;
          if (len_q != otc_pkg::LEN_MAX) begin
            len_d = len_q + {{(otc_pkg::LEN_W-1){1'b0}}, 1'b1};
          end
        end else begin
          scanning_d  = 1'b0;
          res_o.valid = 1'b1;
          if (fin_ok) begin
            res_o.accepted    = 1'b1;
            res_o.token_class = cls_c;
            res_o.op_length   = len_q;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scanning_q <= 1'b0;
      state_q    <= otc_pkg::ST_REGULAR;
    end else begin
      scanning_q <= scanning_d;
      state_q    <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_cls_q <= first_cls_d;
    kind_q      <= kind_d;
    imm_q       <= imm_d;
    bin_q       <= bin_d;
    mask_q      <= mask_d;
    len_q       <= len_d;
  end

endmodule

// ===== hdl/operator_token_classifier.sv =====
// Top level of the operator token classifier: input register, decoder,
// scan state machine and result register. Depends on otc_pkg, otc_if,
// otc_char_class and otc_scan.
//
//  channel | dir | word                                    | handshake
//  in_i    | in  | code_point, start_req, flags, mask       | valid/ready
//  out_o   | out | accepted, token_class, op_length        | valid/ready
//
// One word per cycle sustained while out_o is not stalled; a result leaves through the input
// register, then the result register, once its word is taken.
// The scan state advances once per word, so words may follow back to back.
// Reset clears the valid bits and the scan state.
// A stalled result holds out_o; in_i keeps taking a word while the input
// register can drain into the scanner.
module operator_token_classifier (
  input  logic          clk_i,
  input  logic          rst_ni,
  otc_in_if.sink        in_i,
  otc_out_if.source     out_o
);

  logic                        in_valid_q, in_valid_d;
  logic [otc_pkg::CP_W-1:0]    cp_q;
  logic                        start_q;
  logic                        imm_q;
  logic                        bin_q;
  logic                        una_q;
  logic [otc_pkg::MASK_W-1:0]  mask_q;

  logic                        out_valid_q, out_valid_d;
  logic                        acc_q;
  logic [otc_pkg::CLS_W-1:0]   cls_q;
  logic [otc_pkg::LEN_W-1:0]   len_q;

  logic                        adv;
  otc_pkg::char_info_t         info;
  otc_pkg::scan_res_t          res;

  assign adv        = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || adv;
  assign in_valid_d = in_i.ready ? in_i.valid : in_valid_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (adv && res.valid) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  otc_char_class u_char_class (
    .code_point_i (cp_q),
    .info_o       (info)
  );

  otc_scan u_scan (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .step_i             (adv),
    .start_i            (start_q),
    .immediate_i        (imm_q),
    .binary_all_valid_i (bin_q),
    .unary_any_valid_i  (una_q),
    .allowed_mask_i     (mask_q),
    .info_i             (info),
    .res_o              (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      cp_q    <= in_i.code_point;
      start_q <= in_i.start_req;
      imm_q   <= in_i.immediate;
      bin_q   <= in_i.binary_all_valid;
      una_q   <= in_i.unary_any_valid;
      mask_q  <= in_i.allowed_mask;
    end
    if (adv && res.valid) begin
      acc_q <= res.accepted;
      cls_q <= res.token_class;
      len_q <= res.op_length;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.accepted    = acc_q;
  assign out_o.token_class = cls_q;
  assign out_o.op_length   = len_q;

endmodule

// ===== hdl/otc_checker.sv =====
// Port-level checker for the operator token classifier, bound to the top.
// Depends on otc_pkg and operator_token_classifier_defines.svh.
`include "operator_token_classifier_defines.svh"

module otc_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic                       out_accepted_i,
  input logic [otc_pkg::CLS_W-1:0]  out_token_class_i,
  input logic [otc_pkg::LEN_W-1:0]  out_op_length_i
);

  // a rejected word carries zero class and zero length
  `OTC_ASSERT(a_reject_zero, clk_i, rst_ni, out_valid_i && !out_accepted_i |-> out_token_class_i == '0 && out_op_length_i == '0)

  // an accepted operator spans at least one character and has a known class
  `OTC_ASSERT(a_accept_sane, clk_i, rst_ni, out_valid_i && out_accepted_i |-> out_op_length_i != '0 && out_token_class_i <= otc_pkg::CLS_UNARY)

  // an arrow needs at least two characters
  `OTC_ASSERT_MSG(a_arrow_len, clk_i, rst_ni, out_valid_i && out_accepted_i && out_token_class_i == otc_pkg::CLS_OP0 |-> out_op_length_i >= 8'd2, "arrow shorter than two characters")

  // a stalled result holds its word
  `OTC_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_accepted_i) && $stable(out_token_class_i) && $stable(out_op_length_i))

endmodule

bind operator_token_classifier otc_checker u_otc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_accepted_i    (out_o.accepted),
  .out_token_class_i (out_o.token_class),
  .out_op_length_i   (out_o.op_length)
);

// ===== bench/tb_operator_token_classifier.sv =====
// Self-checking bench for operator_token_classifier: drives character words, predicts tokens.
// Depends on otc_pkg, otc_in_if/otc_out_if and the RTL top; no other files.
// Directed cases first, then random scans; idle and stall bursts on both channels in all but the last phase.
module tb_operator_token_classifier;

  typedef logic [otc_pkg::CP_W-1:0]   cp_t;
  typedef logic [otc_pkg::MASK_W-1:0] mask_t;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned RANDOM_WORDS = 1100;

  localparam cp_t   CH_EOF      = 21'h0;
  localparam cp_t   CH_LOWER_A  = 21'h61;
  localparam cp_t   CP_MAX      = 21'h1FFFFF;
  localparam mask_t ALL_CLASSES = '1;

  typedef struct packed {
    logic                      accepted;
    logic [otc_pkg::CLS_W-1:0] token_class;
    logic [otc_pkg::LEN_W-1:0] op_length;
  } token_t;

  // Tracks the scanner state and keeps the tokens still owed by the block.
  class token_checker;
    token_t                     pending_tokens[$];
    int unsigned                errors;
    logic                       scanning;
    logic [otc_pkg::ST_W-1:0]   scan_state;
    logic [otc_pkg::CLS_W-1:0]  first_class;
    logic [otc_pkg::KIND_W-1:0] first_kind;
    logic                       imm_saved;
    logic                       bin_saved;
    mask_t                      mask_saved;
    logic [otc_pkg::LEN_W-1:0]  length_count;

    function new();
      errors       = 0;
      scanning     = 1'b0;
      scan_state   = otc_pkg::ST_REGULAR;
      first_class  = '0;
      first_kind   = otc_pkg::KIND_PLAIN;
      imm_saved    = 1'b0;
      bin_saved    = 1'b0;
      mask_saved   = '0;
      length_count = '0;
    endfunction

    static function logic [otc_pkg::CLS_W-1:0] op_class(cp_t cp);
      case (cp)
        otc_pkg::CH_DOLLAR: return otc_pkg::CLS_OP10L;
        otc_pkg::CH_CARET:  return otc_pkg::CLS_OP10R;
        otc_pkg::CH_STAR, otc_pkg::CH_PERCENT, otc_pkg::CH_BSLASH, otc_pkg::CH_SLASH:
          return otc_pkg::CLS_OP9;
        otc_pkg::CH_PLUS, otc_pkg::CH_MINUS, otc_pkg::CH_TILDE, otc_pkg::CH_PIPE:
          return otc_pkg::CLS_OP8;
        otc_pkg::CH_AMP:    return otc_pkg::CLS_OP7;
        otc_pkg::CH_DOT:    return otc_pkg::CLS_OP6;
        otc_pkg::CH_EQ, otc_pkg::CH_LT, otc_pkg::CH_GT, otc_pkg::CH_BANG:
          return otc_pkg::CLS_OP5;
        otc_pkg::CH_COLON, otc_pkg::CH_QUEST, otc_pkg::CH_AT:
          return otc_pkg::CLS_OP2;
        21'h2219, 21'h2218, 21'h00D7, 21'h2605, 21'h2297, 21'h2298, 21'h2299,
        21'h229B, 21'h22A0, 21'h22A1, 21'h2229, 21'h2227, 21'h2293:
          return otc_pkg::CLS_OP9;
        21'h00B1, 21'h2295, 21'h2296, 21'h229E, 21'h229F, 21'h222A, 21'h2228,
        21'h2294:
          return otc_pkg::CLS_OP8;
        default:            return otc_pkg::CLS_NONE;
      endcase
    endfunction

    static function logic [otc_pkg::ST_W-1:0] plain_next(logic [otc_pkg::ST_W-1:0] st,
                                                         cp_t cp);
      if (cp == otc_pkg::CH_TILDE || cp == otc_pkg::CH_MINUS) return otc_pkg::ST_MAYBEARROW;
      if (cp == otc_pkg::CH_EQ) return otc_pkg::ST_ASSIGN;
      if (cp == otc_pkg::CH_COLON)
        return (st == otc_pkg::ST_COLON) ? otc_pkg::ST_COLONCOLON : otc_pkg::ST_REGULAR;
      return otc_pkg::ST_REGULAR;
    endfunction

    function void bump_length();
      if (length_count != otc_pkg::LEN_MAX) length_count++;
    endfunction

    function void owe_token(logic acc, logic [otc_pkg::CLS_W-1:0] cls,
                            logic [otc_pkg::LEN_W-1:0] len);
      token_t t;
      t.accepted    = acc;
      t.token_class = acc ? cls : '0;
      t.op_length   = acc ? len : '0;
      pending_tokens.insert(pending_tokens.size(), t);
    endfunction

    function void take_char(cp_t cp, logic start, logic imm, logic bin,
                            logic una, mask_t mask);
      logic [otc_pkg::CLS_W-1:0] cls;
      logic [otc_pkg::ST_W-1:0]  st;
      cls = op_class(cp);
      if (start) begin
        scanning = 1'b0;
        if ((!bin && !una) || cls == otc_pkg::CLS_NONE) begin
          owe_token(1'b0, '0, '0);
          return;
        end
        first_class = cls;
        if (cp == otc_pkg::CH_AT) first_kind = otc_pkg::KIND_SIGIL;
        else if (cp == otc_pkg::CH_LT || cp == otc_pkg::CH_GT || cp == otc_pkg::CH_BANG ||
                 cp == otc_pkg::CH_EQ || cp == otc_pkg::CH_TILDE ||
                 cp == otc_pkg::CH_QUEST) first_kind = otc_pkg::KIND_REL;
        else first_kind = otc_pkg::KIND_PLAIN;
        imm_saved    = imm;
        bin_saved    = bin;
        mask_saved   = mask;
        length_count = 8'd1;
        scanning     = 1'b1;
        case (cp)
          otc_pkg::CH_DOT:   scan_state = otc_pkg::ST_DOT;
          otc_pkg::CH_EQ:    scan_state = otc_pkg::ST_EQUAL;
          otc_pkg::CH_COLON: scan_state = otc_pkg::ST_COLON;
          otc_pkg::CH_MINUS: scan_state = otc_pkg::ST_MINUS;
          default:           scan_state = plain_next(otc_pkg::ST_REGULAR, cp);
        endcase
        return;
      end
      if (!scanning) return;
      if (cls != otc_pkg::CLS_NONE) begin
        st = scan_state;
        // states that may still turn into an arrow; otherwise the char is reprocessed
        if (st == otc_pkg::ST_ASSIGN || st == otc_pkg::ST_EQUAL ||
            st == otc_pkg::ST_MAYBEARROW || st == otc_pkg::ST_MINUS) begin
          if (cp == otc_pkg::CH_GT) begin
            scan_state = otc_pkg::ST_ARROW;
            bump_length();
            return;
          end
          st = otc_pkg::ST_REGULAR;
        end
        scan_state = plain_next(st, cp);
        bump_length();
        return;
      end
      // first non-operator char closes the token
      scanning = 1'b0;
      st = scan_state;
      if (st == otc_pkg::ST_EQUAL || st == otc_pkg::ST_COLON ||
          st == otc_pkg::ST_COLONCOLON || st == otc_pkg::ST_DOT ||
          (st == otc_pkg::ST_MINUS && cp >= otc_pkg::CH_ZERO && cp <= otc_pkg::CH_NINE)) begin
        owe_token(1'b0, '0, '0);
        return;
      end
      cls = first_class;
      if (st == otc_pkg::ST_ARROW) cls = otc_pkg::CLS_OP0;
      else if (st == otc_pkg::ST_ASSIGN && first_kind != otc_pkg::KIND_REL)
        cls = otc_pkg::CLS_OP1;
      if (!imm_saved && cp != otc_pkg::CH_SPACE && cp != otc_pkg::CH_LF &&
          cp != otc_pkg::CH_CR) cls = otc_pkg::CLS_UNARY;
      if (!bin_saved || cls == otc_pkg::CLS_UNARY)
        cls = (first_kind == otc_pkg::KIND_SIGIL) ? otc_pkg::CLS_SIGIL : otc_pkg::CLS_UNARY;
      if (!mask_saved[cls]) owe_token(1'b0, '0, '0);
      else owe_token(1'b1, cls, length_count);
    endfunction

    function void check_token(logic acc, logic [otc_pkg::CLS_W-1:0] cls,
                              logic [otc_pkg::LEN_W-1:0] len);
      token_t want;
      if (pending_tokens.size() == 0) begin
        $display("%0t: unexpected token accepted=%0d class=%0d length=%0d",
                 $time, acc, cls, len);
        errors++;
        return;
      end
      want = pending_tokens.pop_front();
      if (acc !== want.accepted) begin
        $display("%0t: accepted expected %0d actual %0d", $time, want.accepted, acc);
        errors++;
      end
      if (cls !== want.token_class) begin
        $display("%0t: token_class expected %0d actual %0d", $time, want.token_class, cls);
        errors++;
      end
      if (len !== want.op_length) begin
        $display("%0t: op_length expected %0d actual %0d", $time, want.op_length, len);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  otc_in_if  in_if ();
  otc_out_if out_if ();

  operator_token_classifier uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  token_checker      sb = new();
  logic              gaps_on;
  logic              stalls_on;
  int unsigned       stall_left;
  int unsigned       words_sent;
  int unsigned       cycle_count;
  cp_t               op_text[$];

  initial begin
    clk_i = 1'b0;
  end

  always #5 clk_i = ~clk_i;

  // watch both channels at the same edge, input side first
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready)
        sb.take_char(in_if.code_point, in_if.start_req, in_if.immediate,
                     in_if.binary_all_valid, in_if.unary_any_valid, in_if.allowed_mask);
      if (out_if.valid && out_if.ready)
        sb.check_token(out_if.accepted, out_if.token_class, out_if.op_length);
    end
  end

  // receiver drops ready in bursts while stalls_on is set
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      out_if.ready <= (stall_left == 1);
    end else if (stalls_on && $urandom_range(0, 9) == 0) begin
      stall_left   <= $urandom_range(1, 12);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic coin();
    return logic'($urandom_range(0, 1));
  endfunction

  function automatic cp_t random_op_char();
    if (coin()) begin
      case ($urandom_range(0, 5))
        0:       return otc_pkg::CH_MINUS;
        1:       return otc_pkg::CH_EQ;
        2:       return otc_pkg::CH_GT;
        3:       return otc_pkg::CH_COLON;
        4:       return otc_pkg::CH_DOT;
        default: return otc_pkg::CH_TILDE;
      endcase
    end
    case ($urandom_range(0, 39))
      0:       return otc_pkg::CH_DOLLAR;
      1:       return otc_pkg::CH_CARET;
      2:       return otc_pkg::CH_STAR;
      3:       return otc_pkg::CH_PERCENT;
      4:       return otc_pkg::CH_BSLASH;
      5:       return otc_pkg::CH_SLASH;
      6:       return otc_pkg::CH_PLUS;
      7:       return otc_pkg::CH_MINUS;
      8:       return otc_pkg::CH_TILDE;
      9:       return otc_pkg::CH_PIPE;
      10:      return otc_pkg::CH_AMP;
      11:      return otc_pkg::CH_DOT;
      12:      return otc_pkg::CH_EQ;
      13:      return otc_pkg::CH_LT;
      14:      return otc_pkg::CH_GT;
      15:      return otc_pkg::CH_BANG;
      16:      return otc_pkg::CH_COLON;
      17:      return otc_pkg::CH_QUEST;
      18:      return otc_pkg::CH_AT;
      19:      return 21'h2219;
      20:      return 21'h2218;
      21:      return 21'h00D7;
      22:      return 21'h2605;
      23:      return 21'h2297;
      24:      return 21'h2298;
      25:      return 21'h2299;
      26:      return 21'h229B;
      27:      return 21'h22A0;
      28:      return 21'h22A1;
      29:      return 21'h2229;
      30:      return 21'h2227;
      31:      return 21'h2293;
      32:      return 21'h00B1;
      33:      return 21'h2295;
      34:      return 21'h2296;
      35:      return 21'h229E;
      36:      return 21'h229F;
      37:      return 21'h222A;
      38:      return 21'h2228;
      default: return 21'h2294;
    endcase
  endfunction

  function automatic cp_t random_end_char();
    case ($urandom_range(0, 8))
      0, 1:    return otc_pkg::CH_SPACE;
      2:       return otc_pkg::CH_LF;
      3:       return otc_pkg::CH_CR;
      4:       return CH_EOF;
      5:       return cp_t'(otc_pkg::CH_ZERO + $urandom_range(0, 9));
      6:       return cp_t'(CH_LOWER_A + $urandom_range(0, 25));
      default: return cp_t'($urandom_range(0, CP_MAX));
    endcase
  endfunction

  task automatic send_word(input cp_t cp, input logic start, input logic imm,
                           input logic bin, input logic una, input mask_t mask);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_if.valid            <= 1'b1;
    in_if.code_point       <= cp;
    in_if.start_req        <= start;
    in_if.immediate        <= imm;
    in_if.binary_all_valid <= bin;
    in_if.unary_any_valid  <= una;
    in_if.allowed_mask     <= mask;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    words_sent++;
  endtask

  // filler word: flags are don't-care outside a start word
  task automatic send_char(input cp_t cp);
    send_word(cp, 1'b0, coin(), coin(), coin(), mask_t'($urandom));
  endtask

  // sends op_text as one scan, then the closing char
  task automatic run_op(input cp_t term, input logic imm, input logic bin,
                        input logic una, input mask_t mask);
    send_word(op_text[0], 1'b1, imm, bin, una, mask);
    for (int i = 1; i < op_text.size(); i++) send_char(op_text[i]);
    send_char(term);
  endtask

  task automatic random_scan(input int unsigned forced_len);
    int unsigned n;
    cp_t         head;
    mask_t       mask;
    n    = (forced_len != 0) ? forced_len : $urandom_range(0, 5);
    head = ($urandom_range(0, 11) == 0) ? cp_t'($urandom_range(0, CP_MAX))
                                        : random_op_char();
    mask = ($urandom_range(0, 9) < 7) ? ALL_CLASSES : mask_t'($urandom);
    send_word(head, 1'b1, coin(), ($urandom_range(0, 5) != 0), coin(), mask);
    for (int i = 0; i < n; i++) send_char(random_op_char());
    // now and then leave the scan open so the next start drops it
    if ($urandom_range(0, 19) != 0) send_char(random_end_char());
    if ($urandom_range(0, 14) == 0) send_char(cp_t'($urandom_range(0, CP_MAX)));
  endtask

  task automatic random_phase(input int unsigned word_count);
    int unsigned stop_at;
    stop_at = words_sent + word_count;
    while (words_sent < stop_at) random_scan(0);
  endtask

  initial begin
    rst_ni                 = 1'b0;
    gaps_on                = 1'b1;
    stalls_on              = 1'b1;
    stall_left             = 0;
    words_sent             = 0;
    in_if.valid            = 1'b0;
    in_if.code_point       = '0;
    in_if.start_req        = 1'b0;
    in_if.immediate        = 1'b0;
    in_if.binary_all_valid = 1'b0;
    in_if.unary_any_valid  = 1'b0;
    in_if.allowed_mask     = '0;
    out_if.ready           = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    op_text = {otc_pkg::CH_MINUS, otc_pkg::CH_GT};
    run_op(otc_pkg::CH_SPACE, 1'b1, 1'b1, 1'b1, ALL_CLASSES);
    op_text = {otc_pkg::CH_EQ};
    run_op(otc_pkg::CH_SPACE, 1'b1, 1'b1, 1'b1, ALL_CLASSES);
    op_text = {otc_pkg::CH_EQ, otc_pkg::CH_EQ};
    run_op(otc_pkg::CH_SPACE, 1'b1, 1'b1, 1'b1, ALL_CLASSES);
    op_text = {otc_pkg::CH_PLUS, otc_pkg::CH_EQ};
    run_op(otc_pkg::CH_SPACE, 1'b1, 1'b1, 1'b1, ALL_CLASSES);
    op_text = {otc_pkg::CH_COLON};
    run_op(otc_pkg::CH_SPACE, 1'b1, 1'b1, 1'b1, ALL_CLASSES);
    op_text = {otc_pkg::CH_COLON, otc_pkg::CH_COLON};
    run_op(otc_pkg::CH_SPACE, 1'b1, 1'b1, 1'b1, ALL_CLASSES);
    op_text = {otc_pkg::CH_COLON, otc_pkg::CH_COLON, otc_pkg::CH_COLON};
    run_op(otc_pkg::CH_CR, 1'b1, 1'b1, 1'b1, ALL_CLASSES);
    op_text = {otc_pkg::CH_DOT};
    run_op(CH_EOF, 1'b1, 1'b1, 1'b1, ALL_CLASSES);
    op_text = {otc_pkg::CH_DOT, otc_pkg::CH_DOT};
    run_op(otc_pkg::CH_SPACE, 1'b1, 1'b1, 1'b1, ALL_CLASSES);
    op_text = {otc_pkg::CH_MINUS};
    run_op(cp_t'(otc_pkg::CH_ZERO + 5), 1'b1, 1'b1, 1'b1, ALL_CLASSES);
    op_text = {otc_pkg::CH_MINUS};
    run_op(otc_pkg::CH_LF, 1'b0, 1'b1, 1'b1, ALL_CLASSES);
    op_text = {otc_pkg::CH_AT};
    run_op(CH_LOWER_A, 1'b0, 1'b1, 1'b1, ALL_CLASSES);
    op_text = {otc_pkg::CH_AT};
    run_op(otc_pkg::CH_SPACE, 1'b1, 1'b0, 1'b1, ALL_CLASSES);
    op_text = {otc_pkg::CH_CARET};
    run_op(otc_pkg::CH_CR, 1'b1, 1'b0, 1'b1, ALL_CLASSES);
    op_text = {otc_pkg::CH_EQ, otc_pkg::CH_GT};
    run_op(otc_pkg::CH_SPACE, 1'b1, 1'b1, 1'b1, ALL_CLASSES);
    op_text = {21'h00B1, otc_pkg::CH_TILDE, otc_pkg::CH_GT};
    run_op(otc_pkg::CH_SPACE, 1'b1, 1'b1, 1'b1, ALL_CLASSES);
    op_text = {otc_pkg::CH_PERCENT};
    run_op(21'h10FFFF, 1'b1, 1'b1, 1'b0, ALL_CLASSES);
    // class masked off
    op_text = {otc_pkg::CH_AMP};
    run_op(otc_pkg::CH_SPACE, 1'b1, 1'b1, 1'b1, ~(mask_t'(1) << otc_pkg::CLS_OP7));
    // both gates closed, then non-operator first chars
    send_word(otc_pkg::CH_DOLLAR, 1'b1, 1'b1, 1'b0, 1'b0, ALL_CLASSES);
    send_word(CH_LOWER_A, 1'b1, 1'b1, 1'b1, 1'b1, ALL_CLASSES);
    send_word(CP_MAX, 1'b1, 1'b1, 1'b1, 1'b1, ALL_CLASSES);
    // idle word with no scan running
    send_word(otc_pkg::CH_PLUS, 1'b0, 1'b1, 1'b1, 1'b1, ALL_CLASSES);
    // restart drops the open scan
    send_word(otc_pkg::CH_STAR, 1'b1, 1'b1, 1'b1, 1'b1, ALL_CLASSES);
    send_char(otc_pkg::CH_STAR);
    op_text = {21'h00D7, 21'h2605};
    run_op(otc_pkg::CH_SPACE, 1'b1, 1'b1, 1'b1, ALL_CLASSES);

    random_scan(300);
    random_phase(RANDOM_WORDS / 2);

    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending_tokens.size() != 0);

    random_scan(280);
    random_phase(RANDOM_WORDS / 3);

    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    random_phase(RANDOM_WORDS / 6);

    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending_tokens.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== operator_token_classifier.f =====
+incdir+hdl
hdl/otc_pkg.sv
hdl/otc_if.sv
hdl/otc_char_class.sv
hdl/otc_scan.sv
hdl/operator_token_classifier.sv
hdl/otc_checker.sv
bench/tb_operator_token_classifier.sv
